[hdl/rpfp_pkg.sv]
// rpfp_pkg: shared types, codes and constants of the rpc response frame parser
// used by every module under hdl; depends on nothing else
package rpfp_pkg;

  localparam int HEADER_BYTES    = 16;
  localparam int HDR_STORE       = HEADER_BYTES - 1;
  localparam int POS_W           = $clog2(HEADER_BYTES);
  localparam int SIZE_W          = 31;
  localparam int SER_W           = 5;
  localparam int RID_W           = 64;
  localparam int CFG_INDEX_W     = 2;
  localparam int CFG_DATA_W      = 32;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [15:0]       FRAME_MAGIC     = 16'hdabb;
  localparam logic [7:0]        STATUS_OK_CODE  = 8'd20;
  localparam logic [SIZE_W-1:0] MAX_BODY_RESET  = SIZE_W'(1024 * 1024 * 4);
  localparam logic [SER_W-1:0]  SER_RESET       = SER_W'(2);

  // flag byte bit places
  localparam int FLAG_REQUEST_BIT = 7;
  localparam int FLAG_TWOWAY_BIT  = 6;
  localparam int FLAG_EVENT_BIT   = 5;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_BODY = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_SERIAL   = CFG_INDEX_W'(1);

  // result kinds
  localparam logic [1:0] KIND_ACCEPT = 2'd0;
  localparam logic [1:0] KIND_BODY   = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;

  // error codes
  localparam logic [2:0] ERR_NONE    = 3'd0;
  localparam logic [2:0] ERR_MAGIC   = 3'd1;
  localparam logic [2:0] ERR_SIZE    = 3'd2;
  localparam logic [2:0] ERR_SERIAL  = 3'd3;
  localparam logic [2:0] ERR_REQUEST = 3'd4;

  // queue entry operation
  localparam logic OP_HEADER = 1'b0;
  localparam logic OP_BODY   = 1'b1;

  typedef struct packed {
    logic              op;
    logic [2:0]        err;
    logic [7:0]        flag;
    logic [7:0]        status;
    logic [RID_W-1:0]  rid;
    logic [SIZE_W-1:0] size;
    logic [7:0]        data;
    logic              last;
  } entry_t;

endpackage

[hdl/rpfp_queue.sv]
// rpfp_queue: short fifo of classified words between front and back
// depends on rpfp_pkg for entry_t
module rpfp_queue
  import rpfp_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  output logic   full,
  input  logic   pop,
  output logic   not_empty,
  output entry_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t             slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[hdl/rpfp_front.sv]
// rpfp_front: takes stream bytes, collects and checks headers, tracks body length
// depends on rpfp_pkg; pushes classified words into rpfp_queue
module rpfp_front
  import rpfp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        data_byte,
  input  logic [SIZE_W-1:0] max_body_size,
  input  logic [SER_W-1:0]  expected_serialization,
  input  logic              q_full,
  output logic              push,
  output entry_t            push_entry
);

  logic [POS_W-1:0]  byte_pos;
  logic [POS_W-1:0]  byte_pos_next;
  logic              in_body;
  logic              in_body_next;
  logic [SIZE_W-1:0] body_left;
  logic [SIZE_W-1:0] body_left_next;
  logic [7:0]        hdr [HDR_STORE];

  logic              fire;
  logic              hdr_final;
  logic [15:0]       magic;
  logic [31:0]       size_word;
  logic [RID_W-1:0]  rid;
  logic [2:0]        err;

  assign in_ready  = !q_full;
  assign fire      = in_valid && in_ready;
  assign hdr_final = !in_body && (byte_pos == POS_W'(HDR_STORE));

  always_comb begin
    magic     = {hdr[0], hdr[1]};
    size_word = {hdr[12], hdr[13], hdr[14], data_byte};
    rid       = {hdr[4], hdr[5], hdr[6], hdr[7], hdr[8], hdr[9], hdr[10], hdr[11]};
    // first failing check wins
    if (magic != FRAME_MAGIC) begin
      err = ERR_MAGIC;
    end else if (size_word == '0 || size_word[31] ||
                 size_word[SIZE_W-1:0] > max_body_size) begin
      err = ERR_SIZE;
    end else if (hdr[2][SER_W-1:0] != expected_serialization) begin
      err = ERR_SERIAL;
    end else if (hdr[2][FLAG_REQUEST_BIT]) begin
      err = ERR_REQUEST;
    end else begin
      err = ERR_NONE;
    end
  end

  always_comb begin
    byte_pos_next  = byte_pos;
    in_body_next   = in_body;
    body_left_next = body_left;
    push           = 1'b0;
    push_entry     = '0;
    if (in_body) begin
      push_entry.op   = OP_BODY;
      push_entry.data = data_byte;
      push_entry.last = (body_left <= SIZE_W'(1));
      if (fire) begin
        push = 1'b1;
        if (body_left <= SIZE_W'(1)) begin
          body_left_next = '0;
          in_body_next   = 1'b0;
        end else begin
          body_left_next = body_left - 1'b1;
        end
      end
    end else if (hdr_final) begin
      push_entry.op     = OP_HEADER;
      push_entry.err    = err;
      push_entry.flag   = hdr[2];
      push_entry.status = hdr[3];
      push_entry.rid    = rid;
      push_entry.size   = size_word[SIZE_W-1:0];
      if (fire) begin
        push          = 1'b1;
        byte_pos_next = '0;
        // a rejected header resyncs at the very next byte
        if (err == ERR_NONE) begin
          in_body_next   = 1'b1;
          body_left_next = size_word[SIZE_W-1:0];
        end
      end
    end else if (fire) begin
      byte_pos_next = byte_pos + 1'b1;
    end
  end

  // header bytes shift in so that byte k sits in hdr[k] at the final byte
  always_ff @(posedge clk) begin
    if (fire && !in_body && !hdr_final) begin
      for (int i = 0; i < HDR_STORE - 1; i++) begin
        hdr[i] <= hdr[i+1];
      end
      hdr[HDR_STORE-1] <= data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_pos  <= '0;
      in_body   <= 1'b0;
      body_left <= '0;
    end else begin
      byte_pos  <= byte_pos_next;
      in_body   <= in_body_next;
      body_left <= body_left_next;
    end
  end

  a_body_at_frame_start: assert property (@(posedge clk) disable iff (rst)
    in_body |-> (byte_pos == '0 && body_left != '0))
    else $error("body phase with header bytes pending or zero length");

  a_last_ends_body: assert property (@(posedge clk) disable iff (rst)
    (push && push_entry.op == OP_BODY && push_entry.last) |=> !in_body)
    else $error("body phase outlived its last byte");

  a_good_header_opens_body: assert property (@(posedge clk) disable iff (rst)
    (push && push_entry.op == OP_HEADER && push_entry.err == ERR_NONE) |=>
      (in_body && body_left == $past(push_entry.size)))
    else $error("accepted header did not start the body");

  a_bad_header_resyncs: assert property (@(posedge clk) disable iff (rst)
    (push && push_entry.op == OP_HEADER && push_entry.err != ERR_NONE) |=>
      (!in_body && byte_pos == '0))
    else $error("rejected header did not restart header collection");

endmodule

[hdl/rpfp_back.sv]
// rpfp_back: pops classified words and drives the registered result fields
// depends on rpfp_pkg for entry_t and the kind and error codes
module rpfp_back
  import rpfp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              q_not_empty,
  input  entry_t            q_head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        kind,
  output logic [2:0]        error_code,
  output logic              two_way,
  output logic              is_event,
  output logic [7:0]        status,
  output logic              status_ok,
  output logic [RID_W-1:0]  request_id,
  output logic [SIZE_W-1:0] body_size,
  output logic [7:0]        body_byte,
  output logic              last
);

  logic load;
  logic is_hdr;

  assign load   = !out_valid || out_ready;
  assign pop    = q_not_empty && load;
  assign is_hdr = (q_head.op == OP_HEADER);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= q_not_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (is_hdr) begin
        kind <= (q_head.err == ERR_NONE) ? KIND_ACCEPT : KIND_REJECT;
      end else begin
        kind <= KIND_BODY;
      end
      error_code <= is_hdr ? q_head.err : ERR_NONE;
      two_way    <= is_hdr && q_head.flag[FLAG_TWOWAY_BIT];
      is_event   <= is_hdr && q_head.flag[FLAG_EVENT_BIT];
      status     <= is_hdr ? q_head.status : 8'd0;
      status_ok  <= is_hdr && (q_head.status == STATUS_OK_CODE);
      request_id <= is_hdr ? q_head.rid : '0;
      body_size  <= is_hdr ? q_head.size : '0;
      body_byte  <= is_hdr ? 8'd0 : q_head.data;
      last       <= !is_hdr && q_head.last;
    end
  end

endmodule

[hdl/rpc_response_frame_parser.sv]
// rpc_response_frame_parser: top level, configuration registers and part wiring
// depends on rpfp_pkg, rpfp_front, rpfp_queue and rpfp_back
//
// Usage: raw response bytes enter one per word on in_valid/in_ready with
// data_byte. The first 16 bytes of a frame form the header; the 16th byte
// yields one header word (kind accepted or rejected, with the decoded fields
// and an error code), the first 15 yield nothing. After an accepted header the
// next body_size bytes come out one word each as kind body, the final one with
// last set. After a rejected header the next byte starts a new header.
// Results leave on out_valid/out_ready. max_body_size (index 0) and
// expected_serialization (index 1) are written on cfg_valid/cfg_ready with
// cfg_index and cfg_data; cfg_ready is always high, other indexes are dropped.
// Throughput: one byte per cycle while in_ready is high, limited by the
// front's per-byte header check and the queue push. A result enters the
// queue at the edge that accepts its byte, then the output register once
// that register is free. When the receiver stalls, the queue fills and
// in_ready drops once QUEUE_DEPTH results wait in the queue behind the one
// held in the output register. Reset clears the parse position, the body
// count, the queue and the output valid, and restores the register defaults.
module rpc_response_frame_parser
  import rpfp_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             data_byte,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [1:0]             kind,
  output logic [2:0]             error_code,
  output logic                   two_way,
  output logic                   is_event,
  output logic [7:0]             status,
  output logic                   status_ok,
  output logic [RID_W-1:0]       request_id,
  output logic [SIZE_W-1:0]      body_size,
  output logic [7:0]             body_byte,
  output logic                   last
);

  logic [SIZE_W-1:0] max_body_size;
  logic [SER_W-1:0]  expected_serialization;

  logic   q_full;
  logic   q_push;
  entry_t q_push_entry;
  logic   q_pop;
  logic   q_not_empty;
  entry_t q_head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_body_size          <= MAX_BODY_RESET;
      expected_serialization <= SER_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_MAX_BODY: max_body_size          <= cfg_data[SIZE_W-1:0];
        REG_SERIAL:   expected_serialization <= cfg_data[SER_W-1:0];
        default: ;
      endcase
    end
  end

  rpfp_front u_front (
    .clk                    (clk),
    .rst                    (rst),
    .in_valid               (in_valid),
    .in_ready               (in_ready),
    .data_byte              (data_byte),
    .max_body_size          (max_body_size),
    .expected_serialization (expected_serialization),
    .q_full                 (q_full),
    .push                   (q_push),
    .push_entry             (q_push_entry)
  );

  rpfp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .not_empty  (q_not_empty),
    .head       (q_head)
  );

  rpfp_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .pop         (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .kind        (kind),
    .error_code  (error_code),
    .two_way     (two_way),
    .is_event    (is_event),
    .status      (status),
    .status_ok   (status_ok),
    .request_id  (request_id),
    .body_size   (body_size),
    .body_byte   (body_byte),
    .last        (last)
  );

endmodule
